@@ hdl/ucfr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the UART CRC frame receiver.
// No dependencies; every other file of the block imports this package.
package ucfr_pkg;

   localparam int BYTE_W               = 8;
   localparam int CRC_W                = 16;
   localparam int FRAME_LEN_W          = 7;
   localparam int CSR_IDX_W            = 3;
   localparam int CSR_DATA_W           = 16;
   localparam int DEFAULT_PAYLOAD_DEPTH = 64;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_HEAD  = 3'd0,
      CSR_FRAME_TAIL  = 3'd1,
      CSR_CRC_POLY    = 3'd2,
      CSR_CRC_INIT    = 3'd3,
      CSR_CRC_REFLECT = 3'd4,
      CSR_CRC_XOROUT  = 3'd5
   } csr_index_type;

   // register values after reset (CRC-16/MODBUS framing defaults)
   localparam logic [BYTE_W-1:0] HEAD_RST    = 8'hA5;
   localparam logic [BYTE_W-1:0] TAIL_RST    = 8'h5A;
   localparam logic [CRC_W-1:0]  POLY_RST    = 16'h8005;
   localparam logic [CRC_W-1:0]  INIT_RST    = 16'hFFFF;
   localparam logic              REFLECT_RST = 1'b1;
   localparam logic [CRC_W-1:0]  XOROUT_RST  = 16'h0000;

   // control from the frame sequencer to the CRC unit
   typedef struct packed {
      logic              load;
      logic              feed;
      logic [BYTE_W-1:0] data;
   } crc_ctl_type;

endpackage

@@ hdl/ucfr_req_if.sv @@
`timescale 1ns / 1ps
// Input channel of the frame receiver: one received byte per transaction.
// Depends on ucfr_pkg for the byte width.
interface ucfr_req_if;
   import ucfr_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hdl/ucfr_rsp_if.sv @@
`timescale 1ns / 1ps
// Result channel of the frame receiver: one payload byte per transaction.
// Depends on ucfr_pkg for the field widths.
interface ucfr_rsp_if;
   import ucfr_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [BYTE_W-1:0]      payload_byte;
   logic                   payload_last;
   logic [FRAME_LEN_W-1:0] frame_length;

   modport source (output valid, output payload_byte, output payload_last,
                   output frame_length, input ready);
   modport sink   (input valid, input payload_byte, input payload_last,
                   input frame_length, output ready);
endinterface

@@ hdl/uart_crc_frame_receiver.sv @@
`timescale 1ns / 1ps
// UART CRC frame receiver: top level. Depends on ucfr_pkg, ucfr_req_if,
// ucfr_rsp_if, ucfr_payload_ram and ucfr_crc_unit.
//
// Usage:
//   req_chan carries received bytes, one per transaction. Frames are laid out
//   as head, length L, L payload bytes, CRC-16 high, CRC-16 low, tail. A head
//   byte restarts the frame anywhere; bytes outside a frame are ignored.
//   rsp_chan returns the L payload bytes of a frame whose tail and CRC match,
//   with payload_last on the final one and frame_length = L on each.
//   Bad frames, and lengths above PAYLOAD_DEPTH, produce nothing.
//   csr_we/csr_index/csr_wdata write the head, tail and CRC settings; write
//   them only while the block is idle.
// Throughput and drain sequence:
//   req_chan.ready stays high while frames are received. After a good tail
//   the sequencer issues the first RAM read in S_READ and shows the first
//   payload byte in S_OUT, then one byte per cycle as rsp_chan.ready allows,
//   read from the payload RAM. req_chan.ready is low from a good tail until
//   the last payload byte is taken, so input is held off while draining.
// Reset and stall:
//   Reset returns to idle with the default registers (CRC-16/MODBUS, head
//   0xA5, tail 0x5A). A stalled receiver holds the current payload byte.
module uart_crc_frame_receiver #(
   parameter int PAYLOAD_DEPTH = ucfr_pkg::DEFAULT_PAYLOAD_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   ucfr_req_if.sink                         req_chan,
   ucfr_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [ucfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ucfr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ucfr_pkg::*;

   localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam int LEN_W  = $clog2(PAYLOAD_DEPTH + 1);
   localparam int POS_W  = $clog2(PAYLOAD_DEPTH + 5);

   typedef enum logic [1:0] {
      S_RECV,
      S_READ,
      S_OUT
   } state_type;

   // configuration registers
   logic [BYTE_W-1:0] head_ff;
   logic [BYTE_W-1:0] tail_ff;
   logic [CRC_W-1:0]  poly_ff;
   logic [CRC_W-1:0]  init_ff;
   logic              reflect_ff;
   logic [CRC_W-1:0]  xorout_ff;

   // frame state
   state_type         state_ff, state_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0] crc_hi_ff, crc_hi_in;
   logic [BYTE_W-1:0] crc_lo_ff, crc_lo_in;
   logic [ADDR_W-1:0] out_idx_ff, out_idx_in;

   logic              take;
   logic [BYTE_W-1:0] ch;
   logic [POS_W-1:0]  len_ext;
   crc_ctl_type       crc_ctl;
   logic [CRC_W-1:0]  crc_final;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;
   logic              out_last;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= HEAD_RST;
         tail_ff    <= TAIL_RST;
         poly_ff    <= POLY_RST;
         init_ff    <= INIT_RST;
         reflect_ff <= REFLECT_RST;
         xorout_ff  <= XOROUT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_HEAD:  head_ff    <= csr_wdata[BYTE_W-1:0];
            CSR_FRAME_TAIL:  tail_ff    <= csr_wdata[BYTE_W-1:0];
            CSR_CRC_POLY:    poly_ff    <= csr_wdata;
            CSR_CRC_INIT:    init_ff    <= csr_wdata;
            CSR_CRC_REFLECT: reflect_ff <= csr_wdata[0];
            CSR_CRC_XOROUT:  xorout_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign take     = req_chan.valid && req_chan.ready;
   assign ch       = req_chan.rx_byte;
   assign len_ext  = POS_W'(len_ff);
   assign wr_addr  = ADDR_W'(pos_ff - POS_W'(2));
   assign out_last = (LEN_W'(out_idx_ff) + LEN_W'(1)) == len_ff;

   // frame sequencer: parse one byte per transaction, then drain the store
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      crc_hi_in    = crc_hi_ff;
      crc_lo_in    = crc_lo_ff;
      out_idx_in   = out_idx_ff;
      crc_ctl      = '0;
      crc_ctl.data = ch;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      case (state_ff)
         S_RECV: begin
            if (take) begin
               if (ch == head_ff) begin
                  pos_in       = POS_W'(1);
                  len_in       = '0;
                  crc_ctl.load = 1'b1;
               end else if (pos_ff == '0) begin
                  // outside a frame: drop
               end else if (pos_ff == POS_W'(1)) begin
                  if (ch == '0) begin
                     len_in = '0;
                     pos_in = POS_W'(2);
                  end else if (int'(ch) > PAYLOAD_DEPTH) begin
                     len_in = '0;
                     pos_in = '0;
                  end else begin
                     len_in = LEN_W'(ch);
                     pos_in = POS_W'(2);
                  end
               end else if (len_ff == '0) begin
                  // zero length: swallow until the next head
               end else if (pos_ff < len_ext + POS_W'(2)) begin
                  wr_en        = 1'b1;
                  crc_ctl.feed = 1'b1;
                  pos_in       = pos_ff + POS_W'(1);
               end else if (pos_ff == len_ext + POS_W'(2)) begin
                  crc_hi_in = ch;
                  pos_in    = pos_ff + POS_W'(1);
               end else if (pos_ff == len_ext + POS_W'(3)) begin
                  crc_lo_in = ch;
                  pos_in    = pos_ff + POS_W'(1);
               end else begin
                  // tail: check and emit or drop
                  pos_in = '0;
                  if (ch == tail_ff && crc_final == {crc_hi_ff, crc_lo_ff}) begin
                     state_in = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            rd_en      = 1'b1;
            out_idx_in = '0;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (rsp_chan.ready) begin
               if (out_last) begin
                  state_in = S_RECV;
               end else begin
                  rd_en      = 1'b1;
                  rd_addr    = out_idx_ff + ADDR_W'(1);
                  out_idx_in = out_idx_ff + ADDR_W'(1);
               end
            end
         end
         default: state_in = S_RECV;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_RECV;
         pos_ff     <= '0;
         len_ff     <= '0;
         crc_hi_ff  <= '0;
         crc_lo_ff  <= '0;
         out_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         len_ff     <= len_in;
         crc_hi_ff  <= crc_hi_in;
         crc_lo_ff  <= crc_lo_in;
         out_idx_ff <= out_idx_in;
      end
   end

   ucfr_crc_unit u_crc (
      .clock       (clock),
      .reset       (reset),
      .ctl         (crc_ctl),
      .crc_poly    (poly_ff),
      .crc_init    (init_ff),
      .crc_reflect (reflect_ff),
      .crc_xorout  (xorout_ff),
      .crc_final   (crc_final)
   );

   ucfr_payload_ram #(
      .DEPTH  (PAYLOAD_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ch),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // channel outputs
   assign req_chan.ready        = (state_ff == S_RECV);
   assign rsp_chan.valid        = (state_ff == S_OUT);
   assign rsp_chan.payload_byte = rd_data;
   assign rsp_chan.payload_last = out_last;
   assign rsp_chan.frame_length = FRAME_LEN_W'(len_ff);

   // input and output never move in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("input accepted while a payload byte is shown");

   // the final payload byte hands control back to the receiver
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.payload_last |=> req_chan.ready)
      else $error("receiver not resumed after the last payload byte");

   // the read index stays inside the declared length while draining
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (LEN_W'(out_idx_ff) < len_ff))
      else $error("payload read index beyond frame length");

   // no store write while draining the store
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> take && !rd_en)
      else $error("payload store written outside reception");
endmodule

@@ hdl/ucfr_payload_ram.sv @@
`timescale 1ns / 1ps
// Payload byte store: one write port, one read port, registered read data.
// Depends on ucfr_pkg for the byte width.
module ucfr_payload_ram #(
   parameter int DEPTH  = ucfr_pkg::DEFAULT_PAYLOAD_DEPTH,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [ucfr_pkg::BYTE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [ucfr_pkg::BYTE_W-1:0] rd_data
);
   import ucfr_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port with registered output; data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hdl/ucfr_crc_unit.sv @@
`timescale 1ns / 1ps
// Running CRC-16 register with configurable polynomial, init, reflection
// and output XOR. Depends on ucfr_pkg for the control struct and widths.
module ucfr_crc_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  ucfr_pkg::crc_ctl_type       ctl,
   input  logic [ucfr_pkg::CRC_W-1:0]  crc_poly,
   input  logic [ucfr_pkg::CRC_W-1:0]  crc_init,
   input  logic                        crc_reflect,
   input  logic [ucfr_pkg::CRC_W-1:0]  crc_xorout,
   output logic [ucfr_pkg::CRC_W-1:0]  crc_final
);
   import ucfr_pkg::*;

   logic [CRC_W-1:0] crc_ff;
   logic [CRC_W-1:0] crc_in;
   logic [CRC_W-1:0] crc_out;

   function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] r;
      for (int i = 0; i < BYTE_W; i++) begin
         r[i] = v[BYTE_W-1-i];
      end
      return r;
   endfunction

   // shift one byte through the divider, MSB first
   function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] c,
                                                 input logic [BYTE_W-1:0] b,
                                                 input logic [CRC_W-1:0] poly);
      logic [CRC_W-1:0] r;
      r = c ^ {b, {(CRC_W-BYTE_W){1'b0}}};
      for (int i = 0; i < BYTE_W; i++) begin
         r = r[CRC_W-1] ? ((r << 1) ^ poly) : (r << 1);
      end
      return r;
   endfunction

   // load at frame start, advance on each payload byte
   always_comb begin
      crc_in = crc_ff;
      if (ctl.load) begin
         crc_in = crc_init;
      end else if (ctl.feed) begin
         crc_in = crc_step(crc_ff, crc_reflect ? rev8(ctl.data) : ctl.data, crc_poly);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= INIT_RST;
      end else begin
         crc_ff <= crc_in;
      end
   end

   // output reflection swaps bytes and reverses each
   assign crc_out   = crc_reflect ? {rev8(crc_ff[BYTE_W-1:0]), rev8(crc_ff[CRC_W-1:BYTE_W])}
                                  : crc_ff;
   assign crc_final = crc_out ^ crc_xorout;
endmodule
